// ===== rtl/core/k_rough_number_test_core_macros.svh =====
// Assertion macros shared by the core RTL.
`ifndef K_ROUGH_NUMBER_TEST_CORE_MACROS_SVH
`define K_ROUGH_NUMBER_TEST_CORE_MACROS_SVH

// check a property at every clock edge outside reset
`define KRNT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition in one cycle brings a consequence in the next
`define KRNT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/krnt_pkg.sv =====
// Package with field widths and parameter defaults of the rough number test core.
package krnt_pkg;

  localparam int VALUE_W           = 63;
  localparam int BOUND_W           = 10;
  localparam int PRIME_LIMIT_DEF   = 1024;
  localparam int MAX_PRIMES_DEF    = 172;

endpackage

// ===== rtl/core/k_rough_number_test_core.sv =====
// Rough number test core: sieve after reset, then trial division with a shared divider.
//
// After reset the core clears its PRIME_LIMIT+1 entry mark memory, sieves it (a read and a
// check per candidate up to the square root, then a mark write per crossed-out multiple)
// and copies up to MAX_PRIMES primes into the prime table (a read and a check per
// candidate up to PRIME_LIMIT); in_stall stays high until then. Each item is then one
// pass over the primes in ascending order. Every prime up to bound_k costs a table read
// and check and one trial division in the bit-serial restoring divider, and every prime
// factor divided out costs one more division. A zero value goes straight to the result.
// The result sits in an output register; a new item is taken once the core is back to
// idle, even while the last result still waits.
module k_rough_number_test_core
  import krnt_pkg::*;
#(
  parameter int PRIME_LIMIT = PRIME_LIMIT_DEF,
  parameter int MAX_PRIMES  = MAX_PRIMES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [BOUND_W-1:0] in_bound_k,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_is_rough
);

`include "k_rough_number_test_core_macros.svh"

  localparam int AW   = $clog2(PRIME_LIMIT + 1);
  localparam int NW   = $clog2(PRIME_LIMIT + 2);
  localparam int SW   = NW + 1;
  localparam int MW   = NW + 1;
  localparam int CW   = $clog2(MAX_PRIMES + 1);
  localparam int TW   = $clog2(MAX_PRIMES);
  localparam int DCW  = $clog2(VALUE_W);
  localparam int CMW  = (AW > BOUND_W) ? AW : BOUND_W;

  typedef enum logic [3:0] {
    S_CLR, S_SV_RD, S_SV_CHK, S_SV_MARK, S_CO_RD, S_CO_CHK,
    S_IDLE, S_T_RD, S_T_CHK, S_DIV, S_EVAL, S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [NW-1:0]        n_r, n_nxt;
  logic [SW-1:0]        sq_r, sq_nxt;
  logic [MW-1:0]        m_r, m_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [VALUE_W-1:0]   v_r, v_nxt;
  logic [BOUND_W-1:0]   k_r, k_nxt;
  logic [VALUE_W-1:0]   quo_r, quo_nxt;
  logic [AW-1:0]        rem_r, rem_nxt;
  logic [AW-1:0]        p_r, p_nxt;
  logic [DCW-1:0]       dcnt_r, dcnt_nxt;
  logic                 res_r, res_nxt;
  logic                 ready_r, ready_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_is_rough_r, out_is_rough_nxt;

  logic                 marks_mem [0:PRIME_LIMIT];
  logic                 mark_we;
  logic [AW-1:0]        mark_waddr;
  logic                 mark_wdata;
  logic [AW-1:0]        mark_raddr;
  logic                 mark_q;

  logic [AW-1:0]        tbl_mem [0:MAX_PRIMES-1];
  logic                 tbl_we;
  logic [TW-1:0]        tbl_waddr;
  logic                 tbl_re;
  logic [AW-1:0]        tbl_q;

  logic [AW:0]          rem_sh;
  logic                 rem_ge;
  logic [AW:0]          rem_sub;

  always_ff @(posedge clk) begin
    if (mark_we) begin
      marks_mem[mark_waddr] <= mark_wdata;
    end
    mark_q <= marks_mem[mark_raddr];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= n_r[AW-1:0];
    end
    if (tbl_re) begin
      tbl_q <= tbl_mem[idx_r[TW-1:0]];
    end
  end

  assign rem_sh  = {rem_r, quo_r[VALUE_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, p_r};
  assign rem_sub = rem_sh - {1'b0, p_r};

  always_comb begin
    state_nxt        = state_r;
    n_nxt            = n_r;
    sq_nxt           = sq_r;
    m_nxt            = m_r;
    cnt_nxt          = cnt_r;
    idx_nxt          = idx_r;
    v_nxt            = v_r;
    k_nxt            = k_r;
    quo_nxt          = quo_r;
    rem_nxt          = rem_r;
    p_nxt            = p_r;
    dcnt_nxt         = dcnt_r;
    res_nxt          = res_r;
    ready_nxt        = ready_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_is_rough_nxt = out_is_rough_r;
    mark_we          = 1'b0;
    mark_waddr       = n_r[AW-1:0];
    mark_wdata       = 1'b0;
    mark_raddr       = n_r[AW-1:0];
    tbl_we           = 1'b0;
    tbl_waddr        = cnt_r[TW-1:0];
    tbl_re           = 1'b0;

    unique case (state_r)
      S_CLR: begin
        mark_we = 1'b1;
        if (n_r == NW'(PRIME_LIMIT)) begin
          n_nxt     = NW'(2);
          sq_nxt    = SW'(4);
          state_nxt = S_SV_RD;
        end else begin
          n_nxt = n_r + NW'(1);
        end
      end
      S_SV_RD: begin
        if (sq_r > SW'(PRIME_LIMIT)) begin
          n_nxt     = NW'(2);
          state_nxt = S_CO_RD;
        end else begin
          state_nxt = S_SV_CHK;
        end
      end
      S_SV_CHK: begin
        if (!mark_q) begin
          m_nxt     = MW'(sq_r);
          state_nxt = S_SV_MARK;
        end else begin
          n_nxt     = n_r + NW'(1);
          sq_nxt    = sq_r + (SW'(n_r) << 1) + SW'(1);
          state_nxt = S_SV_RD;
        end
      end
      S_SV_MARK: begin
        mark_we    = 1'b1;
        mark_waddr = m_r[AW-1:0];
        mark_wdata = 1'b1;
        m_nxt      = m_r + MW'(n_r);
        if (m_nxt > MW'(PRIME_LIMIT)) begin
          n_nxt     = n_r + NW'(1);
          sq_nxt    = sq_r + (SW'(n_r) << 1) + SW'(1);
          state_nxt = S_SV_RD;
        end
      end
      S_CO_RD: begin
        state_nxt = S_CO_CHK;
      end
      S_CO_CHK: begin
        if (!mark_q && (cnt_r < CW'(MAX_PRIMES))) begin
          tbl_we  = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
        if (n_r == NW'(PRIME_LIMIT)) begin
          ready_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          n_nxt     = n_r + NW'(1);
          state_nxt = S_CO_RD;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          v_nxt   = in_value;
          k_nxt   = in_bound_k;
          idx_nxt = '0;
          if (in_value == '0) begin
            res_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_T_RD;
          end
        end
      end
      S_T_RD: begin
        if (idx_r == cnt_r) begin
          res_nxt   = v_r > VALUE_W'(k_r);
          state_nxt = S_DONE;
        end else begin
          tbl_re    = 1'b1;
          state_nxt = S_T_CHK;
        end
      end
      S_T_CHK: begin
        if (CMW'(tbl_q) > CMW'(k_r)) begin
          res_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          p_nxt     = tbl_q;
          quo_nxt   = v_r;
          rem_nxt   = '0;
          dcnt_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt  = rem_ge ? rem_sub[AW-1:0] : rem_sh[AW-1:0];
        quo_nxt  = {quo_r[VALUE_W-2:0], rem_ge};
        dcnt_nxt = dcnt_r + DCW'(1);
        if (dcnt_r == DCW'(VALUE_W - 1)) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (rem_r == '0) begin
          v_nxt = quo_r;
          if (quo_r <= VALUE_W'(k_r)) begin
            res_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else begin
            rem_nxt   = '0;
            dcnt_nxt  = '0;
            state_nxt = S_DIV;
          end
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_T_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt    = 1'b1;
          out_is_rough_nxt = res_r;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      n_r         <= '0;
      cnt_r       <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      cnt_r       <= cnt_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sq_r           <= sq_nxt;
    m_r            <= m_nxt;
    idx_r          <= idx_nxt;
    v_r            <= v_nxt;
    k_r            <= k_nxt;
    quo_r          <= quo_nxt;
    rem_r          <= rem_nxt;
    p_r            <= p_nxt;
    dcnt_r         <= dcnt_nxt;
    res_r          <= res_nxt;
    out_is_rough_r <= out_is_rough_nxt;
  end

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_rough = out_is_rough_r;

  `KRNT_ASSERT(a_stall_until_ready, !ready_r |-> in_stall, "item taken before sieve done")
  `KRNT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "core idle after item")
  `KRNT_ASSERT(a_count_bound, cnt_r <= CW'(MAX_PRIMES), "prime count past table size")
  `KRNT_ASSERT_NEXT(a_done_loads_out, (state_r == S_DONE) && !out_valid_r, out_valid,
    "finished item not delivered")

endmodule

// ===== dv/k_rough_number_test_core_test.sv =====
// Testbench for the rough number test core: random and directed items checked against a trial-division predictor.
module k_rough_number_test_core_test;
  import krnt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int          RANDOM_ITEMS = 76;
  localparam int          SMALL_BOUND_MAX = 60;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [BOUND_W-1:0] bound_k;
    bit                 hold_until_drained;
  } trial_item_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [BOUND_W-1:0] bound_k;
    bit                 is_rough;
  } verdict_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [VALUE_W-1:0] in_value = '0;
  logic [BOUND_W-1:0] in_bound_k = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_is_rough;

  bit [9:0]    prime_list [MAX_PRIMES_DEF];
  int          n_primes;
  trial_item_t pending_q [$];
  verdict_t    rough_verdict_q [$];
  trial_item_t next_item;
  verdict_t    oldest;
  int          items_total;
  int          large_bounds;
  int          items_accepted = 0;
  int          results_checked = 0;
  int          rough_seen = 0;
  int          verdict_errors = 0;
  bit          accept_now;

  k_rough_number_test_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_value    (in_value),
    .in_bound_k  (in_bound_k),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_is_rough(out_is_rough)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit predict_rough(logic [VALUE_W-1:0] value, logic [BOUND_W-1:0] bound_k);
    logic [63:0] quotient;
    int          idx;
    quotient = {1'b0, value};
    if (quotient == 0) return 1'b0;
    for (idx = 0; idx < n_primes; idx++) begin
      if (prime_list[idx] > bound_k) return 1'b1;
      while (quotient % prime_list[idx] == 0) begin
        quotient = quotient / prime_list[idx];
        if (quotient <= bound_k) return 1'b0;
      end
    end
    return quotient > bound_k;
  endfunction

  function automatic void queue_item(logic [63:0] value, logic [BOUND_W-1:0] bound_k,
                                     bit hold = 1'b0);
    trial_item_t item;
    item.value = value[VALUE_W-1:0];
    item.bound_k = bound_k;
    item.hold_until_drained = hold;
    pending_q.insert(pending_q.size(), item);
    items_total++;
    if (bound_k > SMALL_BOUND_MAX) large_bounds++;
  endfunction

  function automatic bit calm_window(int count);
    return count >= 40 && count < 70;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      accept_now = in_valid && !in_stall;
      if (accept_now) begin
        oldest.value = in_value;
        oldest.bound_k = in_bound_k;
        oldest.is_rough = predict_rough(in_value, in_bound_k);
        rough_verdict_q.insert(rough_verdict_q.size(), oldest);
        items_accepted <= items_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_q.size() != 0
            && (calm_window(items_accepted) || $urandom_range(99) >= 19)
            && (!pending_q[0].hold_until_drained
                || results_checked == items_accepted + accept_now)) begin
          next_item = pending_q.pop_front();
          in_valid <= 1'b1;
          in_value <= next_item.value;
          in_bound_k <= next_item.bound_k;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked <= results_checked + 1;
        if (rough_verdict_q.size() == 0) begin
          verdict_errors++;
          if (verdict_errors <= 10)
            $display("ERROR: result is_rough=%0b with no item outstanding", out_is_rough);
        end else begin
          oldest = rough_verdict_q.pop_front();
          if (out_is_rough) rough_seen++;
          if (out_is_rough !== oldest.is_rough) begin
            verdict_errors++;
            if (verdict_errors <= 10)
              $display("ERROR: value=%0d bound_k=%0d is_rough expected %0b, got %0b",
                       oldest.value, oldest.bound_k, oldest.is_rough, out_is_rough);
          end
        end
      end
      out_stall <= !calm_window(results_checked) && $urandom_range(99) < 19;
    end
  end

  initial begin
    bit          composite [PRIME_LIMIT_DEF+1];
    int          n;
    int          m;
    int          pick;
    logic [63:0] v;
    logic [63:0] p;
    logic [BOUND_W-1:0] k;

    n_primes = 0;
    items_total = 0;
    large_bounds = 0;
    for (n = 2; n * n <= PRIME_LIMIT_DEF; n++)
      if (!composite[n])
        for (m = n * n; m <= PRIME_LIMIT_DEF; m += n) composite[m] = 1'b1;
    for (n = 2; n <= PRIME_LIMIT_DEF; n++) begin
      if (!composite[n] && n_primes < MAX_PRIMES_DEF) begin
        prime_list[n_primes] = 10'(n);
        n_primes++;
      end
    end

    queue_item(0, 5);
    queue_item(0, 1023);
    queue_item(1, 1);
    queue_item(1, 0);
    queue_item(12345, 0);
    queue_item(VALUE_MAX, 1023);
    queue_item(VALUE_MAX, 1);
    queue_item(64'h4000_0000_0000_0000, 1);
    queue_item(64'h4000_0000_0000_0000, 1023);
    queue_item(1021 * 1021, 1023);
    queue_item(1071209, 1023);
    queue_item(1071209, 1021);
    queue_item(1071209, 1020);
    queue_item(1031, 1023);
    queue_item(1019, 1023);
    queue_item(1024, 1023);
    queue_item(6, 2);
    queue_item(6, 3);
    queue_item(2, 1);
    queue_item(2, 2);
    queue_item(64'd4052555153018976267, 2);
    queue_item(64'd4052555153018976267, 3);
    queue_item(997 * 3, 996);
    queue_item(64'h2AAA_AAAA_5555_5555, 512);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(99) < 85) k = BOUND_W'($urandom_range(0, SMALL_BOUND_MAX));
      else k = BOUND_W'($urandom_range(SMALL_BOUND_MAX + 1, 1023));
      pick = $urandom_range(99);
      if (pick < 35) begin
        v = 64'($urandom_range(1, 2 * int'(k) + 2));
        repeat ($urandom_range(1, 10)) begin
          p = 64'(prime_list[$urandom_range(0, 14)]);
          if (v <= VALUE_MAX / p) v = v * p;
        end
      end else if (pick < 65) begin
        v = {$urandom, $urandom};
        v[63] = 1'b0;
      end else if (pick < 80) begin
        v = 64'($urandom_range(0, 4095));
      end else begin
        p = 64'(prime_list[$urandom_range(0, n_primes - 1)]);
        v = 64'($urandom_range(1, 3));
        repeat ($urandom_range(1, 12)) if (v <= VALUE_MAX / p) v = v * p;
      end
      queue_item(v, k, n == 0 || n == RANDOM_ITEMS / 2);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (items_accepted != items_total || results_checked != items_total) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Covered %0d items (%0d with bounds above %0d, zero values, prime powers, smooth",
             items_total, large_bounds, SMALL_BOUND_MAX);
    $display("and random values): %0d verdicts checked, %0d rough, %0d not rough.",
             results_checked, rough_seen, results_checked - rough_seen);
    if (verdict_errors == 0 && rough_verdict_q.size() == 0 && results_checked == items_total)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/krnt_pkg.sv
rtl/core/k_rough_number_test_core.sv
dv/k_rough_number_test_core_test.sv
